>>> src/chunk_progress_tracker_assert.svh
// assertion macros for the chunk progress tracker
// expects a clock named clk and an active-high reset named rst in the using module
`ifndef CHUNK_PROGRESS_TRACKER_ASSERT_SVH
`define CHUNK_PROGRESS_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CPT_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CPT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPT_ASSERT_ALWAYS(label, expr, msg)
`define CPT_ASSERT_IMPLY(label, ante, cons, msg)
`define CPT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/cpt_pkg.sv
// shared constants for the chunk progress tracker
// no dependencies
`default_nettype none

package cpt_pkg;

  localparam int MAX_CHUNKS   = 1024;
  localparam int DIGEST_WORDS = 4;

  localparam int COUNT_W  = 11;
  localparam int LIMIT_W  = 48;
  localparam int INDEX_W  = 16;
  localparam int BYTES_W  = 32;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 1;

  localparam int IDX_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int TOT_W   = $clog2(MAX_CHUNKS + 1);
  localparam int BYTE_W  = BYTES_W + TOT_W;
  localparam int CMP_W   = (BYTE_W > LIMIT_W) ? BYTE_W : LIMIT_W;
  localparam int CMPI_W  = INDEX_W + 1;
  localparam int DIG_W   = WORD_W * DIGEST_WORDS;
  localparam int ENTRY_W = 1 + BYTES_W + DIG_W;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SIZE     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT  = 1'd1;

endpackage

`default_nettype wire

>>> src/cpt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module cpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output      logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/chunk_progress_tracker.sv
// chunk progress tracker top level: control, totals and per-chunk entry memory
// depends on cpt_pkg, cpt_ram and chunk_progress_tracker_assert.svh
//
// requests enter on in_valid/in_stall, one at a time. a chunk record passes
// through a memory read, then compare and write back of the same entry, and
// gives no result. a report request walks all MAX_CHUNKS entries of the entry
// memory, one per cycle, finding the lowest missing index and clearing each
// entry; after the walk and a drain state its result is loaded onto
// out_valid, and the next request is taken once the tracker is idle again.
// results sit in an output register: a stalled result holds while the next
// record requests are taken; a later report waits at its end for the slot.
// after reset a clearing pass over all MAX_CHUNKS entries runs with
// in_stall high; configuration writes are taken at any time.
// cfg_write/cfg_index/cfg_data write the chunk count (index 0) or size_limit (1).
`default_nettype none

`include "chunk_progress_tracker_assert.svh"

module chunk_progress_tracker
  import cpt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic                  req_type,
  input  wire logic [INDEX_W-1:0]    chunk_index,
  input  wire logic [BYTES_W-1:0]    chunk_bytes,
  input  wire logic [WORD_W-1:0]     digest_w0,
  input  wire logic [WORD_W-1:0]     digest_w1,
  input  wire logic [WORD_W-1:0]     digest_w2,
  input  wire logic [WORD_W-1:0]     digest_w3,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [STATUS_W-1:0]   status,
  output      logic [LIMIT_W-1:0]    received_bytes,
  output      logic [COUNT_W-1:0]    received_chunks,
  output      logic [COUNT_W-1:0]    next_missing
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;

  logic [COUNT_W-1:0]  num_chunks;
  logic [LIMIT_W-1:0]  size_limit;

  logic [BYTE_W-1:0]   byte_total;
  logic [TOT_W-1:0]    chunk_total;
  logic [STATUS_W-1:0] error_code;

  logic [IDX_W-1:0]    idx_q;
  logic [BYTES_W-1:0]  bytes_q;
  logic [DIG_W-1:0]    digest_q;
  logic                rec_ok_q;

  logic [IDX_W-1:0]    scan_addr;
  logic [IDX_W-1:0]    addr_q;
  logic                pend;
  logic                reporting;
  logic                found;
  logic [CMPI_W-1:0]   miss;
  logic [STATUS_W-1:0] rep_status;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [CMPI_W-1:0]   ec_wide;
  logic                in_accept;
  logic                range_bad;
  logic [4*WORD_W-1:0] digest_all;
  logic                entry_valid;
  logic                entry_match;
  logic                scan_last;
  logic                out_load;
  logic [STATUS_W-1:0] rep_status_next;

  assign ec_wide = (CMPI_W'(num_chunks) > CMPI_W'(MAX_CHUNKS)) ? CMPI_W'(MAX_CHUNKS)
                                                              : CMPI_W'(num_chunks);
  assign in_stall    = (state != ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign range_bad   = (CMPI_W'(chunk_index) >= ec_wide);
  assign digest_all  = {digest_w3, digest_w2, digest_w1, digest_w0};
  assign entry_valid = ram_rdata[ENTRY_W-1];
  assign entry_match = (ram_rdata[ENTRY_W-2:0] == {bytes_q, digest_q});
  assign scan_last   = (scan_addr == IDX_W'(MAX_CHUNKS - 1));
  assign out_load    = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    if (error_code != STATUS_OK) begin
      rep_status_next = error_code;
    end else if (ec_wide == '0) begin
      rep_status_next = STATUS_RANGE;
    end else if (CMP_W'(byte_total) > CMP_W'(size_limit)) begin
      rep_status_next = STATUS_SIZE;
    end else begin
      rep_status_next = STATUS_OK;
    end
  end

  always_comb begin
    ram_raddr = (state == ST_IDLE) ? chunk_index[IDX_W-1:0] : scan_addr;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    if (state == ST_REC && rec_ok_q && !entry_valid) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      ram_wdata = {1'b1, bytes_q, digest_q};
    end else if (pend) begin
      ram_we    = 1'b1;
      ram_waddr = addr_q;
      ram_wdata = '0;
    end
  end

  cpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CHUNKS)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SCAN;
      num_chunks  <= COUNT_W'(1);
      size_limit  <= '0;
      byte_total  <= '0;
      chunk_total <= '0;
      error_code  <= STATUS_OK;
      scan_addr   <= '0;
      pend        <= 1'b0;
      reporting   <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CHUNK_COUNT: num_chunks <= cfg_data[COUNT_W-1:0];
          CFG_SIZE_LIMIT:  size_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      pend <= (state == ST_SCAN);
      if (pend && reporting && !found && !ram_rdata[ENTRY_W-1]
          && (CMPI_W'(addr_q) < ec_wide)) begin
        miss  <= CMPI_W'(addr_q);
        found <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (req_type) begin
              rep_status <= rep_status_next;
              miss       <= ec_wide;
              found      <= 1'b0;
              reporting  <= 1'b1;
              scan_addr  <= '0;
              state      <= ST_SCAN;
            end else begin
              idx_q    <= chunk_index[IDX_W-1:0];
              bytes_q  <= chunk_bytes;
              digest_q <= digest_all[DIG_W-1:0];
              rec_ok_q <= (error_code == STATUS_OK) && !range_bad;
              if (error_code == STATUS_OK && range_bad) begin
                error_code <= STATUS_RANGE;
              end
              state <= ST_REC;
            end
          end
        end
        ST_REC: begin
          if (rec_ok_q) begin
            if (entry_valid) begin
              if (!entry_match) begin
                error_code <= STATUS_CONFLICT;
              end
            end else begin
              byte_total  <= byte_total + BYTE_W'(bytes_q);
              chunk_total <= chunk_total + TOT_W'(1);
            end
          end
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          addr_q <= scan_addr;
          if (scan_last) begin
            state <= ST_DRAIN;
          end else begin
            scan_addr <= scan_addr + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= reporting ? ST_DONE : ST_IDLE;
        end
        ST_DONE: begin
          if (out_load) begin
            status <= rep_status;
            if (rep_status == STATUS_OK) begin
              received_bytes  <= LIMIT_W'(byte_total);
              received_chunks <= COUNT_W'(chunk_total);
              next_missing    <= miss[COUNT_W-1:0];
            end else begin
              received_bytes  <= '0;
              received_chunks <= '0;
              next_missing    <= '0;
            end
            byte_total  <= '0;
            chunk_total <= '0;
            error_code  <= STATUS_OK;
            reporting   <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CPT_ASSERT_ALWAYS(a_chunk_total_bound, chunk_total <= TOT_W'(MAX_CHUNKS), "chunk total above max")
  `CPT_ASSERT_IMPLY(a_out_from_done, $rose(out_valid), $past(state) == ST_DONE, "result not from report end")
  `CPT_ASSERT_NEXT(a_record_to_rec, in_accept && !req_type, state == ST_REC, "record did not enter compare")
  `CPT_ASSERT_IMPLY(a_error_zero_fields, out_valid && status != STATUS_OK, received_bytes == '0 && received_chunks == '0 && next_missing == '0, "error result has nonzero fields")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for chunk_progress_tracker: directed and random chunk records and
// progress reports, random idling on both sides, expected reports from a local tracker model
// depends on cpt_pkg and the chunk_progress_tracker rtl
module tb_top;
  import cpt_pkg::*;

  localparam int LONG_HOLD      = 3000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_CYCLES     = 1100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEM_TARGET    = 950;
  localparam int REPORT_TARGET  = 40;
  localparam int TAIL_ITEMS     = 850;

  typedef logic [3:0][WORD_W-1:0] digest_t;

  typedef struct packed {
    logic               rtype;
    logic [INDEX_W-1:0] index;
    logic [BYTES_W-1:0] nbytes;
    digest_t            dig;
  } chunk_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LIMIT_W-1:0]  nbytes;
    logic [COUNT_W-1:0]  nchunks;
    logic [COUNT_W-1:0]  missing;
  } progress_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CHUNK_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 req_type = 1'b0;
  logic [INDEX_W-1:0]   chunk_index = '0;
  logic [BYTES_W-1:0]   chunk_bytes = '0;
  logic [WORD_W-1:0]    digest_w0 = '0;
  logic [WORD_W-1:0]    digest_w1 = '0;
  logic [WORD_W-1:0]    digest_w2 = '0;
  logic [WORD_W-1:0]    digest_w3 = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [LIMIT_W-1:0]   received_bytes;
  logic [COUNT_W-1:0]   received_chunks;
  logic [COUNT_W-1:0]   next_missing;

  chunk_progress_tracker dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .chunk_index     (chunk_index),
    .chunk_bytes     (chunk_bytes),
    .digest_w0       (digest_w0),
    .digest_w1       (digest_w1),
    .digest_w2       (digest_w2),
    .digest_w3       (digest_w3),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .received_bytes  (received_bytes),
    .received_chunks (received_chunks),
    .next_missing    (next_missing)
  );

  // tracker model state
  logic [COUNT_W-1:0]    cnt_reg = 11'd1;
  logic [LIMIT_W-1:0]    lim_reg = '0;
  logic [MAX_CHUNKS-1:0] seen_map = '0;
  logic [BYTES_W-1:0]    size_tab [MAX_CHUNKS];
  digest_t               dig_tab [MAX_CHUNKS];
  logic [LIMIT_W-1:0]    byte_sum = '0;
  logic [COUNT_W-1:0]    chunk_sum = '0;
  logic [STATUS_W-1:0]   err_state = STATUS_OK;

  chunk_req_t pending_reqs [$];
  progress_t  pending_reports [$];
  chunk_req_t next_req;
  chunk_req_t taken_req;
  progress_t  want;

  int   items_sent = 0;
  int   reports_sent = 0;
  int   mismatches = 0;
  int   in_gap = 0;
  int   out_burst = 0;
  int   hold_cnt = 0;
  int   idle_cnt = 0;
  int   in_mode = 0;
  int   out_mode = 0;
  logic [7:0] mode_cnt = '0;
  logic tail_quiet = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_count();
    return (cnt_reg > MAX_CHUNKS) ? MAX_CHUNKS : int'(cnt_reg);
  endfunction

  function automatic void track_chunk(chunk_req_t r);
    int unsigned eff;
    bit same;
    eff = eff_count();
    if (err_state != STATUS_OK) return;
    if (r.index >= eff) begin
      err_state = STATUS_RANGE;
      return;
    end
    if (seen_map[r.index]) begin
      same = (size_tab[r.index] == r.nbytes);
      for (int w = 0; w < DIGEST_WORDS; w++)
        if (dig_tab[r.index][w] != r.dig[w]) same = 1'b0;
      if (!same) err_state = STATUS_CONFLICT;
    end else begin
      seen_map[r.index] = 1'b1;
      size_tab[r.index] = r.nbytes;
      for (int w = 0; w < DIGEST_WORDS; w++)
        dig_tab[r.index][w] = r.dig[w];
      byte_sum = byte_sum + LIMIT_W'(r.nbytes);
      chunk_sum = chunk_sum + 1'b1;
    end
  endfunction

  function automatic void report_progress();
    progress_t p;
    int unsigned eff, miss;
    eff = eff_count();
    p = '0;
    p.status = err_state;
    if (p.status == STATUS_OK && eff == 0) p.status = STATUS_RANGE;
    if (p.status == STATUS_OK && byte_sum > lim_reg) p.status = STATUS_SIZE;
    if (p.status == STATUS_OK) begin
      miss = eff;
      for (int unsigned i = 0; i < eff; i++)
        if (!seen_map[i] && miss == eff) miss = i;
      p.nbytes = byte_sum;
      p.nchunks = chunk_sum;
      p.missing = COUNT_W'(miss);
    end
    pending_reports.insert(pending_reports.size(), p);
    seen_map = '0;
    byte_sum = '0;
    chunk_sum = '0;
    err_state = STATUS_OK;
  endfunction

  function automatic digest_t rand_digest();
    digest_t d;
    for (int w = 0; w < 4; w++) d[w] = {$urandom, $urandom};
    return d;
  endfunction

  function automatic chunk_req_t rand_req();
    chunk_req_t r;
    r.rtype = 1'b0;
    r.index = INDEX_W'($urandom);
    r.nbytes = $urandom;
    r.dig = rand_digest();
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] count_word(int unsigned cnt);
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    rnd[COUNT_W-1:0] = cnt[COUNT_W-1:0];
    return rnd[CFG_W-1:0];
  endfunction

  function automatic int pick_mode();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 2;
      default: return 7;
    endcase
  endfunction

  task automatic push_req(chunk_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
    items_sent++;
    if (r.rtype) reports_sent++;
  endtask

  task automatic push_report();
    chunk_req_t r;
    r = rand_req();
    r.rtype = 1'b1;
    push_req(r);
  endtask

  task automatic push_rec(int unsigned idx, logic [BYTES_W-1:0] nb, digest_t dg);
    chunk_req_t r;
    r.rtype = 1'b0;
    r.index = INDEX_W'(idx);
    r.nbytes = nb;
    r.dig = dg;
    push_req(r);
  endtask

  // one upload: mostly new chunks, some matching repeats, rare conflicts and noise
  task automatic push_upload(int unsigned eff, bit small_bytes, bit with_report);
    chunk_req_t sent [$];
    chunk_req_t r;
    int unsigned n, pick, f, pos;
    n = (eff == 0) ? 2 : ((eff <= 12) ? eff : $urandom_range(3, 12));
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 39);
      r = rand_req();
      if (pick == 0) begin
        r.rtype = 1'($urandom_range(0, 1));
      end else if (pick == 1 || eff == 0) begin
        r.index = INDEX_W'($urandom_range(eff, 65535));
      end else if (pick == 2 && sent.size() != 0) begin
        r = sent[$urandom_range(0, sent.size() - 1)];
        f = $urandom_range(0, DIGEST_WORDS);
        if (f == 0) begin
          pos = $urandom_range(0, BYTES_W - 1);
          r.nbytes = r.nbytes ^ (BYTES_W'(1) << pos);
        end else begin
          pos = $urandom_range(0, WORD_W - 1);
          r.dig[f-1] = r.dig[f-1] ^ (WORD_W'(1) << pos);
        end
      end else if (pick <= 8 && sent.size() != 0) begin
        r = sent[$urandom_range(0, sent.size() - 1)];
      end else begin
        if (pick == 39) r.index = INDEX_W'(eff - 1);
        else if (eff <= 12 && pick >= 16) r.index = INDEX_W'(k);
        else r.index = INDEX_W'($urandom_range(0, eff - 1));
        if (small_bytes) r.nbytes = BYTES_W'($urandom_range(0, 511));
        sent.insert(sent.size(), r);
      end
      push_req(r);
    end
    if (with_report) push_report();
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_CHUNK_COUNT) cnt_reg = val[COUNT_W-1:0];
    else lim_reg = val[LIMIT_W-1:0];
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || pending_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        req_type <= next_req.rtype;
        chunk_index <= next_req.index;
        chunk_bytes <= next_req.nbytes;
        digest_w0 <= next_req.dig[0];
        digest_w1 <= next_req.dig[1];
        digest_w2 <= next_req.dig[2];
        digest_w3 <= next_req.dig[3];
        if (!tail_quiet && in_mode != 0 && $urandom_range(0, in_mode) == 0)
          in_gap <= $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_burst <= 0;
    end else if (long_hold_req && !long_hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == LONG_HOLD - 1) long_hold_done <= 1'b1;
    end else if (out_burst != 0) begin
      out_stall <= 1'b1;
      out_burst <= out_burst - 1;
    end else if (!tail_quiet && out_mode != 0 && $urandom_range(0, out_mode) == 0) begin
      out_stall <= 1'b1;
      out_burst <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    mode_cnt <= mode_cnt + 1'b1;
    if (mode_cnt == 0) begin
      in_mode <= pick_mode();
      out_mode <= pick_mode();
    end
  end

  // request monitor feeding the model
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      taken_req.rtype = req_type;
      taken_req.index = chunk_index;
      taken_req.nbytes = chunk_bytes;
      taken_req.dig = {digest_w3, digest_w2, digest_w1, digest_w0};
      if (req_type) report_progress();
      else track_chunk(taken_req);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: status %0d bytes %0d chunks %0d missing %0d",
               status, received_bytes, received_chunks, next_missing);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (received_bytes !== want.nbytes) begin
          $error("received_bytes: expected %0d, got %0d", want.nbytes, received_bytes);
          mismatches++;
        end
        if (received_chunks !== want.nchunks) begin
          $error("received_chunks: expected %0d, got %0d", want.nchunks, received_chunks);
          mismatches++;
        end
        if (next_missing !== want.missing) begin
          $error("next_missing: expected %0d, got %0d", want.missing, next_missing);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    digest_t d, d2;
    logic [63:0] rnd;
    int unsigned cnt, eff, nup;
    logic [LIMIT_W-1:0] lim;
    bit small_bytes;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, duplicates, range error, conflict, ignore after error
    write_cfg(CFG_CHUNK_COUNT, count_word(4));
    write_cfg(CFG_SIZE_LIMIT, '1);
    d = rand_digest();
    push_rec(0, '0, '0);
    push_rec(1, '1, '1);
    push_rec(3, 32'd100, d);
    push_rec(1, '1, '1);
    push_report();
    push_rec(0, 32'd5, d);
    push_rec(4, 32'd5, d);
    push_report();
    d = rand_digest();
    d2 = d;
    d2[3] = ~d2[3];
    push_rec(2, 32'd7, d);
    push_rec(2, 32'd7, d2);
    push_rec(65535, '1, d);
    push_report();
    push_report();
    wait_drained();

    // size limit zero
    write_cfg(CFG_SIZE_LIMIT, '0);
    push_rec(0, 32'd1, rand_digest());
    push_report();
    push_rec(0, 32'd0, rand_digest());
    push_report();
    wait_drained();

    // chunk count zero
    write_cfg(CFG_CHUNK_COUNT, count_word(0));
    push_rec(0, 32'd3, rand_digest());
    push_report();
    push_report();
    wait_drained();

    // chunk count above the table size
    write_cfg(CFG_CHUNK_COUNT, count_word(2047));
    write_cfg(CFG_SIZE_LIMIT, '1);
    push_rec(MAX_CHUNKS - 1, 32'd9, rand_digest());
    push_report();
    push_rec(MAX_CHUNKS, 32'd9, rand_digest());
    push_report();
    wait_drained();

    // count lowered while chunks are held
    write_cfg(CFG_CHUNK_COUNT, count_word(8));
    for (int i = 0; i < 4; i++) push_rec(i, BYTES_W'($urandom_range(0, 1000)), rand_digest());
    wait_drained();
    write_cfg(CFG_CHUNK_COUNT, count_word(3));
    push_report();
    wait_drained();

    // back pressure: hold results so reports queue up and the input stalls
    long_hold_req = 1'b1;
    write_cfg(CFG_CHUNK_COUNT, count_word(4));
    push_report();
    push_report();
    push_upload(4, 1'b1, 1'b1);
    push_upload(4, 1'b0, 1'b1);

    while (items_sent < ITEM_TARGET || reports_sent < REPORT_TARGET) begin
      wait_drained();
      if (items_sent >= TAIL_ITEMS) tail_quiet = 1'b1;
      case ($urandom_range(0, 19))
        0: cnt = 0;
        1: cnt = MAX_CHUNKS;
        2: cnt = $urandom_range(MAX_CHUNKS + 1, 2047);
        3, 4: cnt = $urandom_range(13, MAX_CHUNKS - 1);
        default: cnt = $urandom_range(1, 12);
      endcase
      rnd = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0, 1: lim = '1;
        2: lim = '0;
        3: lim = LIMIT_W'($urandom_range(0, 3000));
        4: lim = rnd[LIMIT_W-1:0];
        default: lim = LIMIT_W'($urandom_range(0, 40000));
      endcase
      write_cfg(CFG_CHUNK_COUNT, count_word(cnt));
      write_cfg(CFG_SIZE_LIMIT, lim);
      eff = (cnt > MAX_CHUNKS) ? MAX_CHUNKS : cnt;
      small_bytes = 1'($urandom_range(0, 1));
      nup = $urandom_range(1, 4);
      for (int unsigned u = 0; u < nup; u++)
        push_upload(eff, small_bytes, (u + 1 < nup) || ($urandom_range(0, 4) != 0));
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected reports never arrived", pending_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
